// File: design/icalc_pkg.sv
package icalc_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_VALUE_W = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // operator codes, the two high codes bind tighter
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT,
    S_FIN,
    S_OUT
  } state_t;

  // request to the arithmetic unit
  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  // status back from the arithmetic unit
  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_stat_t;

  // multiply and divide bind tighter than add and subtract
  function automatic logic is_tight(input op_t op);
    is_tight = (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage

// File: design/icalc_alu.sv
module icalc_alu #(
  parameter int unsigned W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  icalc_pkg::alu_req_t req,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output icalc_pkg::alu_stat_t stat,
  output logic [W-1:0]        result
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  icalc_pkg::op_t   op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     x_r, x_nxt;
  logic [W-1:0]     y_r, y_nxt;
  logic             neg_r, neg_nxt;
  logic             done_r, done_nxt;
  logic             dz_r, dz_nxt;
  logic [W-1:0]     res_r, res_nxt;

  logic [W-1:0]     abs_a, abs_b;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  // magnitudes for the divider
  assign abs_a = a[W-1] ? (~a + 1'b1) : a;
  assign abs_b = b[W-1] ? (~b + 1'b1) : b;

  // restoring divide step: bring in the next dividend bit and try the divisor
  assign shifted = {acc_r, x_r[W-1]};
  assign diff    = shifted - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    dz_nxt   = dz_r;
    res_nxt  = res_r;
    if (req.start) begin
      op_nxt = req.op;
      dz_nxt = 1'b0;
      unique case (req.op)
        icalc_pkg::OP_ADD: begin
          res_nxt  = a + b;
          done_nxt = 1'b1;
        end
        icalc_pkg::OP_SUB: begin
          res_nxt  = a - b;
          done_nxt = 1'b1;
        end
        icalc_pkg::OP_MUL: begin
          acc_nxt  = '0;
          x_nxt    = b;
          y_nxt    = a;
          cnt_nxt  = CNT_W'(W);
          busy_nxt = 1'b1;
        end
        default: begin
          if (b == '0) begin
            res_nxt  = '0;
            dz_nxt   = 1'b1;
            done_nxt = 1'b1;
          end else begin
            acc_nxt  = '0;
            x_nxt    = abs_a;
            y_nxt    = abs_b;
            neg_nxt  = a[W-1] ^ b[W-1];
            cnt_nxt  = CNT_W'(W);
            busy_nxt = 1'b1;
          end
        end
      endcase
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        // finish: pick product or signed quotient
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == icalc_pkg::OP_MUL) begin
          res_nxt = acc_r;
        end else begin
          res_nxt = neg_r ? (~x_r + 1'b1) : x_r;
        end
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (op_r == icalc_pkg::OP_MUL) begin
          // shift-add multiply, low bits only
          if (x_r[0]) begin
            acc_nxt = acc_r + y_r;
          end
          x_nxt = x_r >> 1;
          y_nxt = y_r << 1;
        end else if (!diff[W]) begin
          acc_nxt = diff[W-1:0];
          x_nxt   = {x_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = shifted[W-1:0];
          x_nxt   = {x_r[W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
      op_r   <= icalc_pkg::OP_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign stat.done     = done_r;
  assign stat.div_zero = dz_r;
  assign result        = res_r;

endmodule

// File: design/infix_integer_expression_evaluator_core.sv
// channel | ports                          | payload
// --------+--------------------------------+---------------------------------------
// input   | in_tvalid/in_tready/in_tdata   | tdata[7:0] char_code, tlast = last
// output  | out_tvalid/out_tready/out_tdata| tdata[31:0] value, [32] div_by_zero
//
// a space or digit is taken while idle; a reduction runs on the shared unit, which adds or
// subtracts in a single step and multiplies or divides one bit per step, an operator is then
// stacked, the last character pushes its operand and drains; up to three reductions (two multiply/divide)
// rst_n is synchronous and active low; counts, accumulator and flags clear, stack entries do not
// in_tready is high only while idle; a result waiting on out_tready does not
// block the next expression until its own final result is ready
module infix_integer_expression_evaluator_core #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [icalc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] char_code
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [icalc_pkg::OUT_TDATA_W-1:0]    out_tdata   // [31:0] value, [32] div_by_zero
);

  localparam int unsigned W = VALUE_WIDTH;

  icalc_pkg::state_t state_r, state_nxt;

  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt;
  logic [1:0]     opnd_cnt_r, opnd_cnt_nxt;
  icalc_pkg::op_t o0_r, o0_nxt, o1_r, o1_nxt;
  logic [1:0]     opr_cnt_r, opr_cnt_nxt;
  icalc_pkg::op_t pend_r, pend_nxt;
  logic           err_r, err_nxt;
  logic           fin_r, fin_nxt;
  logic           drain_r, drain_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [icalc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  icalc_pkg::alu_req_t  alu_req;
  icalc_pkg::alu_stat_t alu_stat;
  logic [W-1:0]         alu_a, alu_b, alu_res;

  logic [7:0]     ch;
  logic           in_fire;
  logic           is_digit;
  icalc_pkg::op_t ch_op;
  logic [W-1:0]   acc_digit;
  logic           do_reduce;
  logic [W-1:0]   final_val;
  logic [icalc_pkg::OUT_VALUE_W-1:0] val_out;

  assign ch       = in_tdata;
  assign in_fire  = in_tvalid && in_tready;
  assign is_digit = (ch >= icalc_pkg::CHAR_ZERO) && (ch <= icalc_pkg::CHAR_NINE);

  // operator decode, anything unknown divides
  always_comb begin
    unique case (ch)
      icalc_pkg::CHAR_PLUS:  ch_op = icalc_pkg::OP_ADD;
      icalc_pkg::CHAR_MINUS: ch_op = icalc_pkg::OP_SUB;
      icalc_pkg::CHAR_STAR:  ch_op = icalc_pkg::OP_MUL;
      default:               ch_op = icalc_pkg::OP_DIV;
    endcase
  end

  // acc * 10 + digit as two shifts and adds
  assign acc_digit = (acc_r << 3) + (acc_r << 1) + W'(ch - icalc_pkg::CHAR_ZERO);

  // operands for a reduction, a missing entry reads as zero
  assign alu_b = (opnd_cnt_r != 2'd0) ? s0_r : '0;
  assign alu_a = (opnd_cnt_r >= 2'd2) ? s1_r : '0;

  // reduce while operators remain, except, unless draining, a loose top under a tight newcomer
  assign do_reduce = (opr_cnt_r != 2'd0) &&
                     (drain_r || !(!icalc_pkg::is_tight(o0_r) &&
                                   icalc_pkg::is_tight(pend_r)));

  assign final_val = (opnd_cnt_r != 2'd0) ? s0_r : '0;

  // fit the value to the 32-bit field
  generate
    if (W >= icalc_pkg::OUT_VALUE_W) begin : g_trunc
      assign val_out = final_val[icalc_pkg::OUT_VALUE_W-1:0];
    end else begin : g_ext
      assign val_out = {{(icalc_pkg::OUT_VALUE_W - W){1'b0}}, final_val};
    end
  endgenerate

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    opnd_cnt_nxt  = opnd_cnt_r;
    o0_nxt        = o0_r;
    o1_nxt        = o1_r;
    opr_cnt_nxt   = opr_cnt_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    fin_nxt       = fin_r;
    drain_nxt     = drain_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    alu_req.start = 1'b0;
    alu_req.op    = o0_r;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      icalc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          fin_nxt = in_tlast;
          if (ch == icalc_pkg::CHAR_SPACE) begin
            if (in_tlast) begin
              state_nxt = icalc_pkg::S_FIN;
            end
          end else if (is_digit) begin
            acc_nxt = acc_digit;
            if (in_tlast) begin
              state_nxt = icalc_pkg::S_FIN;
            end
          end else begin
            // push the pending operand, then settle precedence
            if (opnd_cnt_r != 2'd3) begin
              s0_nxt       = acc_r;
              s1_nxt       = s0_r;
              s2_nxt       = s1_r;
              opnd_cnt_nxt = opnd_cnt_r + 1'b1;
            end
            acc_nxt   = '0;
            pend_nxt  = ch_op;
            state_nxt = icalc_pkg::S_CHECK;
          end
        end
      end

      icalc_pkg::S_CHECK: begin
        if (do_reduce) begin
          alu_req.start = 1'b1;
          state_nxt     = icalc_pkg::S_WAIT;
        end else if (drain_r) begin
          state_nxt = icalc_pkg::S_OUT;
        end else begin
          if (opr_cnt_r != 2'd2) begin
            o0_nxt      = pend_r;
            o1_nxt      = o0_r;
            opr_cnt_nxt = opr_cnt_r + 1'b1;
          end
          state_nxt = fin_r ? icalc_pkg::S_FIN : icalc_pkg::S_IDLE;
        end
      end

      icalc_pkg::S_WAIT: begin
        if (alu_stat.done) begin
          // pop two operands and one operator, push the result
          s0_nxt       = alu_res;
          s1_nxt       = s2_r;
          opnd_cnt_nxt = (opnd_cnt_r >= 2'd2) ? (opnd_cnt_r - 1'b1) : 2'd1;
          o0_nxt       = o1_r;
          opr_cnt_nxt  = opr_cnt_r - 1'b1;
          err_nxt      = err_r | alu_stat.div_zero;
          state_nxt    = icalc_pkg::S_CHECK;
        end
      end

      icalc_pkg::S_FIN: begin
        // last operand, then drain every operator
        if (opnd_cnt_r != 2'd3) begin
          s0_nxt       = acc_r;
          s1_nxt       = s0_r;
          s2_nxt       = s1_r;
          opnd_cnt_nxt = opnd_cnt_r + 1'b1;
        end
        acc_nxt   = '0;
        drain_nxt = 1'b1;
        state_nxt = icalc_pkg::S_CHECK;
      end

      icalc_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{(icalc_pkg::OUT_TDATA_W - icalc_pkg::OUT_VALUE_W - 1){1'b0}},
                           err_r, val_out};
          out_valid_nxt = 1'b1;
          acc_nxt       = '0;
          opnd_cnt_nxt  = 2'd0;
          opr_cnt_nxt   = 2'd0;
          err_nxt       = 1'b0;
          fin_nxt       = 1'b0;
          drain_nxt     = 1'b0;
          state_nxt     = icalc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = icalc_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icalc_pkg::S_IDLE;
      acc_r       <= '0;
      opnd_cnt_r  <= 2'd0;
      opr_cnt_r   <= 2'd0;
      err_r       <= 1'b0;
      fin_r       <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      opnd_cnt_r  <= opnd_cnt_nxt;
      opr_cnt_r   <= opr_cnt_nxt;
      err_r       <= err_nxt;
      fin_r       <= fin_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stack entries and payload
  always_ff @(posedge clk) begin
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    o0_r       <= o0_nxt;
    o1_r       <= o1_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  // shared add, subtract, multiply and divide unit
  icalc_alu #(
    .W (W)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .stat   (alu_stat),
    .result (alu_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/infix_integer_expression_evaluator_core_tb.sv
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_core_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // one evaluated expression
  typedef struct packed {
    logic [icalc_pkg::OUT_VALUE_W-1:0] value;
    logic                              div_by_zero;
  } calc_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [icalc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;    // [7:0] char_code
  logic                              in_tlast = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [icalc_pkg::OUT_TDATA_W-1:0] out_tdata;        // [31:0] value, [32] div_by_zero

  // expected expression values, oldest first
  calc_result_t expected_results[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;

  // evaluator state mirrored by the testbench
  logic [icalc_pkg::OUT_VALUE_W-1:0] acc_digits;
  logic [icalc_pkg::OUT_VALUE_W-1:0] operand_vals[3];
  int unsigned                       n_operands;
  icalc_pkg::op_t                    pending_ops[2];
  int unsigned                       n_ops;
  logic                              saw_div_zero;

  infix_integer_expression_evaluator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void clear_calc();
    acc_digits = '0;
    operand_vals[0] = '0;
    operand_vals[1] = '0;
    operand_vals[2] = '0;
    n_operands = 0;
    pending_ops[0] = icalc_pkg::OP_ADD;
    pending_ops[1] = icalc_pkg::OP_ADD;
    n_ops = 0;
    saw_div_zero = 1'b0;
  endfunction

  function automatic logic mul_or_div(input icalc_pkg::op_t op);
    return (op == icalc_pkg::OP_MUL) || (op == icalc_pkg::OP_DIV);
  endfunction

  function automatic void push_operand(input logic [icalc_pkg::OUT_VALUE_W-1:0] v);
    if (n_operands < 3) begin
      operand_vals[n_operands] = v;
      n_operands++;
    end
  endfunction

  function automatic logic [icalc_pkg::OUT_VALUE_W-1:0] pop_operand();
    if (n_operands == 0) return '0;
    n_operands--;
    return operand_vals[n_operands];
  endfunction

  // wrapping arithmetic, division truncates toward zero
  function automatic logic [icalc_pkg::OUT_VALUE_W-1:0] apply_operator(
      input icalc_pkg::op_t op,
      input logic [icalc_pkg::OUT_VALUE_W-1:0] a,
      input logic [icalc_pkg::OUT_VALUE_W-1:0] b);
    logic [icalc_pkg::OUT_VALUE_W-1:0] mag_a;
    logic [icalc_pkg::OUT_VALUE_W-1:0] mag_b;
    logic [icalc_pkg::OUT_VALUE_W-1:0] quo;
    case (op)
      icalc_pkg::OP_ADD: return a + b;
      icalc_pkg::OP_SUB: return a - b;
      icalc_pkg::OP_MUL: return a * b;
      default: begin
        if (b == '0) begin
          saw_div_zero = 1'b1;
          return '0;
        end
        mag_a = a[icalc_pkg::OUT_VALUE_W-1] ? -a : a;
        mag_b = b[icalc_pkg::OUT_VALUE_W-1] ? -b : b;
        quo = mag_a / mag_b;
        if (a[icalc_pkg::OUT_VALUE_W-1] ^ b[icalc_pkg::OUT_VALUE_W-1]) quo = -quo;
        return quo;
      end
    endcase
  endfunction

  function automatic void reduce_top();
    logic [icalc_pkg::OUT_VALUE_W-1:0] rhs;
    logic [icalc_pkg::OUT_VALUE_W-1:0] lhs;
    icalc_pkg::op_t op;
    rhs = pop_operand();
    lhs = pop_operand();
    op = pending_ops[(n_ops - 1) % 2];
    n_ops--;
    push_operand(apply_operator(op, lhs, rhs));
  endfunction

  // reduce while the stacked operator binds at least as tight, then stack it
  function automatic void take_operator(input icalc_pkg::op_t op);
    push_operand(acc_digits);
    acc_digits = '0;
    while (n_ops != 0 && !(!mul_or_div(pending_ops[(n_ops - 1) % 2]) && mul_or_div(op)))
      reduce_top();
    if (n_ops < 2) begin
      pending_ops[n_ops] = op;
      n_ops++;
    end
  endfunction

  // one accepted character; returns 1 with the value when it ends an expression
  function automatic logic evaluate_char(input logic [7:0] ch, input logic is_last,
      output calc_result_t res);
    res = '0;
    if (ch == icalc_pkg::CHAR_SPACE) begin
      // skipped
    end else if (ch >= icalc_pkg::CHAR_ZERO && ch <= icalc_pkg::CHAR_NINE) begin
      acc_digits = acc_digits * 10 + {24'd0, ch - icalc_pkg::CHAR_ZERO};
    end else if (ch == icalc_pkg::CHAR_PLUS) begin
      take_operator(icalc_pkg::OP_ADD);
    end else if (ch == icalc_pkg::CHAR_MINUS) begin
      take_operator(icalc_pkg::OP_SUB);
    end else if (ch == icalc_pkg::CHAR_STAR) begin
      take_operator(icalc_pkg::OP_MUL);
    end else begin
      take_operator(icalc_pkg::OP_DIV);
    end
    if (!is_last) return 1'b0;
    push_operand(acc_digits);
    while (n_ops != 0) reduce_top();
    res.value = (n_operands != 0) ? operand_vals[(n_operands - 1) % 3] : '0;
    res.div_by_zero = saw_div_zero;
    clear_calc();
    return 1'b1;
  endfunction

  // result side: check each transaction, drive ready with stalls and hold-offs
  always @(posedge clk) begin
    calc_result_t want;
    int unsigned hold_left;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result value=%0d div_by_zero=%0b",
               $signed(out_tdata[icalc_pkg::OUT_VALUE_W-1:0]),
               out_tdata[icalc_pkg::OUT_VALUE_W]);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[icalc_pkg::OUT_VALUE_W-1:0] !== want.value) begin
          $error("value: expected %0d, actual %0d", $signed(want.value),
                 $signed(out_tdata[icalc_pkg::OUT_VALUE_W-1:0]));
          mismatches++;
        end
        if (out_tdata[icalc_pkg::OUT_VALUE_W] !== want.div_by_zero) begin
          $error("div_by_zero: expected %0b, actual %0b", want.div_by_zero,
                 out_tdata[icalc_pkg::OUT_VALUE_W]);
          mismatches++;
        end
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one character and keep it until the transaction completes
  task automatic send_char(input logic [7:0] ch, input logic is_last);
    calc_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    if (evaluate_char(ch, is_last, res)) expected_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // sender pauses until every pending expression has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // mostly well-formed expressions with random operands, some raw byte noise
  task automatic send_random_expr();
    logic [7:0] text[$];
    int unsigned n_terms;
    int unsigned n_digits;
    int unsigned pick;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255)));
    end else begin
      n_terms = $urandom_range(5, 1);
      for (int t = 0; t < n_terms; t++) begin
        if ($urandom_range(9) == 0) text.push_back(icalc_pkg::CHAR_SPACE);
        pick = $urandom_range(99);
        if (pick < 8) n_digits = 0;
        else if (pick < 80) n_digits = $urandom_range(3, 1);
        else if (pick < 92) n_digits = $urandom_range(7, 4);
        else n_digits = $urandom_range(12, 9);
        repeat (n_digits) text.push_back(icalc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        if (t != n_terms - 1 || $urandom_range(9) == 0) begin
          pick = $urandom_range(99);
          if (pick < 24) text.push_back(icalc_pkg::CHAR_PLUS);
          else if (pick < 48) text.push_back(icalc_pkg::CHAR_MINUS);
          else if (pick < 72) text.push_back(icalc_pkg::CHAR_STAR);
          else if (pick < 96) text.push_back(CHAR_SLASH);
          else text.push_back(8'($urandom_range(255)));
        end
      end
    end
    if (text.size() == 0) text.push_back(icalc_pkg::CHAR_SPACE);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // extremes and special cases
  task automatic test_directed();
    send_idle_pct = 18;
    recv_idle_pct = 68;
    // overflowing operand wraps to most negative, divided by minus one
    send_text("6442450944/4294967295");
    // all four operators with precedence, last one divides by zero
    send_text("7-3*2+5/0");
    // blank expression
    send_text(" ");
    // unknown bytes act as divide, operator as final character
    send_char(8'h38, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h32, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h33, 1'b0);
    send_char(icalc_pkg::CHAR_MINUS, 1'b1);
    wait_drain();
  endtask

  task automatic test_random(input int unsigned sender_pct, input int unsigned receiver_pct,
      input int unsigned item_target);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    while (items_sent < item_target) send_random_expr();
    wait_drain();
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (6) send_random_expr();
    wait_drain();
  endtask

  initial begin
    clear_calc();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(18, 68, 300);
    test_backpressure();
    test_random(68, 18, 550);
    test_random(0, 0, 800);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/icalc_pkg.sv
design/icalc_alu.sv
design/infix_integer_expression_evaluator_core.sv
tb/infix_integer_expression_evaluator_core_tb.sv
